### rtl/smis_pkg.sv
// shared types and constants for the stack machine instruction step unit
`timescale 1ns / 1ps
package smis_pkg;
	localparam int DATA_DEPTH = 64;
	localparam int CALL_DEPTH = 16;
	localparam int RAM_WORDS = 16;
	localparam int PROG_SIZE = 256;
	localparam int DPTR_W = $clog2(DATA_DEPTH);
	localparam int DCNT_W = $clog2(DATA_DEPTH + 1);
	localparam int RPTR_W = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int RCNT_W = $clog2(CALL_DEPTH + 1);
	localparam int RAM_W = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
	localparam logic [31:0] POISON = 32'h8000_0000;

	localparam logic [7:0] OP_PUSH = 8'h41, OP_PUSHM = 8'h61, OP_POP = 8'h42;
	localparam logic [7:0] OP_POPM = 8'h62, OP_ADD = 8'h43, OP_SUB = 8'h44;
	localparam logic [7:0] OP_DIV = 8'h45, OP_MUL = 8'h46, OP_ROOT = 8'h47;
	localparam logic [7:0] OP_HALT = 8'h48, OP_JMP = 8'h49, OP_OUT = 8'h4A;
	localparam logic [7:0] OP_CALL = 8'h4B, OP_IN = 8'h4C, OP_RET = 8'h4D;
	localparam logic [7:0] OP_BNE = 8'h4E, OP_COPY = 8'h4F, OP_BGT = 8'h50;
	localparam logic [7:0] OP_BLT = 8'h52, OP_BEQ = 8'h53;
	localparam logic [7:0] REG_W = 8'h57, REG_Z = 8'h5A;

	typedef enum logic [3:0] {
		ERR_NONE = 4'd0, ERR_OPCODE = 4'd1, ERR_REG = 4'd2, ERR_UNDER = 4'd3,
		ERR_OVER = 4'd4, ERR_ADDR = 4'd5, ERR_DIV0 = 4'd6, ERR_CALL = 4'd7,
		ERR_NEGROOT = 4'd8, ERR_TARGET = 4'd9
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_ITER, ST_WB, ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the input beat
		logic rd_top;   // read stack top
		logic rd_next;  // read the entry below top
		logic decide;   // evaluate faults and start
		logic iter;     // one step of divide / root
		logic commit;   // write back state and form result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic iterate;
		logic iter_done;
	} sts_t;
endpackage

### rtl/smis_ctrl.sv
// sequencing state machine for one instruction
`timescale 1ns / 1ps
module smis_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid_hs,
	input  logic            out_stall,
	input  smis_pkg::sts_t  sts,
	output smis_pkg::cmd_t  cmd
);
	smis_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= smis_pkg::ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid_hs = 1'b0;
		case (state_q)
			smis_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = smis_pkg::ST_RD1;
				end
			end
			smis_pkg::ST_RD1: begin
				cmd.rd_top = 1'b1;
				state_nx = smis_pkg::ST_RD2;
			end
			smis_pkg::ST_RD2: begin
				cmd.rd_next = 1'b1;
				state_nx = smis_pkg::ST_EXEC;
			end
			smis_pkg::ST_EXEC: begin
				cmd.decide = 1'b1;
				state_nx = sts.iterate ? smis_pkg::ST_ITER : smis_pkg::ST_WB;
			end
			smis_pkg::ST_ITER: begin
				if (sts.iter_done) state_nx = smis_pkg::ST_WB;
				else cmd.iter = 1'b1;
			end
			smis_pkg::ST_WB: begin
				cmd.commit = 1'b1;
				state_nx = smis_pkg::ST_OUT;
			end
			smis_pkg::ST_OUT: begin
				out_valid_hs = 1'b1;
				if (!out_stall) state_nx = smis_pkg::ST_IDLE;
			end
			default: state_nx = smis_pkg::ST_IDLE;
		endcase
	end
endmodule

### rtl/smis_dpath.sv
// datapath: stacks, registers, ram, alu and iterative divide / root unit
`timescale 1ns / 1ps
module smis_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  smis_pkg::cmd_t     cmd,
	output smis_pkg::sts_t     sts,
	input  logic [7:0]         pc,
	input  logic [7:0]         opcode,
	input  logic [7:0]         operand_one,
	input  logic [7:0]         operand_two,
	input  logic signed [31:0] input_value,
	output logic [7:0]         next_pc,
	output logic signed [31:0] out_value,
	output logic               out_valid,
	output logic               halted,
	output logic [3:0]         error_code
);
	logic [31:0] dstk [smis_pkg::DATA_DEPTH];
	logic [7:0]  rstk [smis_pkg::CALL_DEPTH];
	logic [31:0] regs_q [4];
	logic [31:0] ram_q [smis_pkg::RAM_WORDS];

	logic [smis_pkg::DCNT_W-1:0] dcnt_q;
	logic [smis_pkg::RCNT_W-1:0] rcnt_q;
	logic [7:0] pc_q, op_q, a1_q, a2_q;
	logic [31:0] inval_q, x_q, y_q, rtop_q;

	// latched decision
	logic [3:0] err_q;
	logic [8:0] nxt_q;
	logic halt_q, ovalid_q;
	logic [31:0] res_q;

	// iterative unit: restoring divide or bitwise root
	logic [31:0] acc_q, quo_q, bit_q, div_q;
	logic [5:0] cnt_q;
	logic neg_q, is_root_q;

	// decode
	logic is_reg;
	logic [1:0] ridx;
	logic [7:0] v8, t8;
	logic ram_ok, t1_ok, t2_ok, taken;
	logic [31:0] dx, v32;
	logic dfull, dempty, dtwo, rfull, rempty;

	assign is_reg = (a1_q >= smis_pkg::REG_W) && (a1_q <= smis_pkg::REG_Z);
	assign ridx = 2'(a1_q - smis_pkg::REG_W);
	assign v8 = a1_q - 8'd32;
	assign t8 = a2_q - 8'd32;
	assign v32 = 32'(a1_q) - 32'd32;
	assign ram_ok = (a1_q >= 8'd32) && (32'(v8) < 32'(smis_pkg::RAM_WORDS));
	assign t1_ok = (a1_q >= 8'd32) && (32'(v8) < 32'(smis_pkg::PROG_SIZE));
	assign t2_ok = (a2_q >= 8'd32) && (32'(t8) < 32'(smis_pkg::PROG_SIZE));
	assign dx = regs_q[3];
	assign dfull = 32'(dcnt_q) >= 32'(smis_pkg::DATA_DEPTH);
	assign dempty = dcnt_q == '0;
	assign dtwo = 32'(dcnt_q) >= 32'd2;
	assign rfull = 32'(rcnt_q) >= 32'(smis_pkg::CALL_DEPTH);
	assign rempty = rcnt_q == '0;

	always_comb begin
		case (op_q)
			smis_pkg::OP_BNE: taken = dx != v32;
			smis_pkg::OP_BGT: taken = $signed(v32) < $signed(dx);
			smis_pkg::OP_BLT: taken = $signed(dx) < $signed(v32);
			smis_pkg::OP_BEQ: taken = dx == v32;
			default: taken = 1'b0;
		endcase
	end

	// decide: fault and next pc
	logic [3:0] err_d;
	logic [8:0] nxt_d;
	logic halt_d, iter_d;
	logic [8:0] pc9;
	assign pc9 = {1'b0, pc_q};

	always_comb begin
		err_d = smis_pkg::ERR_NONE;
		nxt_d = pc9 + 9'd1;
		halt_d = 1'b0;
		iter_d = 1'b0;
		case (op_q)
			smis_pkg::OP_PUSH, smis_pkg::OP_IN: begin
				if (op_q == smis_pkg::OP_PUSH) nxt_d = pc9 + 9'd2;
				if (dfull) err_d = smis_pkg::ERR_OVER;
			end
			smis_pkg::OP_PUSHM: begin
				nxt_d = pc9 + 9'd2;
				if (!ram_ok) err_d = smis_pkg::ERR_ADDR;
				else if (dfull) err_d = smis_pkg::ERR_OVER;
			end
			smis_pkg::OP_POP: begin
				nxt_d = pc9 + 9'd2;
				if (!is_reg) err_d = smis_pkg::ERR_REG;
				else if (dempty) err_d = smis_pkg::ERR_UNDER;
			end
			smis_pkg::OP_POPM: begin
				nxt_d = pc9 + 9'd2;
				if (!ram_ok) err_d = smis_pkg::ERR_ADDR;
				else if (dempty) err_d = smis_pkg::ERR_UNDER;
			end
			smis_pkg::OP_ADD, smis_pkg::OP_SUB, smis_pkg::OP_MUL: begin
				if (!dtwo) err_d = smis_pkg::ERR_UNDER;
			end
			smis_pkg::OP_DIV: begin
				if (!dtwo) err_d = smis_pkg::ERR_UNDER;
				else if (y_q == '0) err_d = smis_pkg::ERR_DIV0;
				else iter_d = 1'b1;
			end
			smis_pkg::OP_ROOT: begin
				if (dempty) err_d = smis_pkg::ERR_UNDER;
				else if (x_q[31]) err_d = smis_pkg::ERR_NEGROOT;
				else iter_d = 1'b1;
			end
			smis_pkg::OP_HALT: begin
				halt_d = 1'b1;
				nxt_d = pc9;
			end
			smis_pkg::OP_JMP: begin
				if (!t1_ok) err_d = smis_pkg::ERR_TARGET;
				else nxt_d = {1'b0, v8};
			end
			smis_pkg::OP_OUT: begin
				if (dempty) err_d = smis_pkg::ERR_UNDER;
			end
			smis_pkg::OP_CALL: begin
				if (!t1_ok) err_d = smis_pkg::ERR_TARGET;
				else if (rfull) err_d = smis_pkg::ERR_CALL;
				else nxt_d = {1'b0, v8};
			end
			smis_pkg::OP_RET: begin
				if (rempty) err_d = smis_pkg::ERR_CALL;
				else nxt_d = {1'b0, rtop_q[7:0]};
			end
			smis_pkg::OP_BNE, smis_pkg::OP_BGT, smis_pkg::OP_BLT, smis_pkg::OP_BEQ: begin
				if (!taken) nxt_d = pc9 + 9'd3;
				else if (!t2_ok) err_d = smis_pkg::ERR_TARGET;
				else if (t8 > pc_q && rfull) err_d = smis_pkg::ERR_CALL;
				else nxt_d = {1'b0, t8};
			end
			smis_pkg::OP_COPY: begin
				nxt_d = pc9 + 9'd2;
				if (is_reg && dempty) err_d = smis_pkg::ERR_UNDER;
			end
			default: err_d = smis_pkg::ERR_OPCODE;
		endcase
		if (err_d != smis_pkg::ERR_NONE) begin
			halt_d = 1'b1;
			nxt_d = pc9;
			iter_d = 1'b0;
		end else if (!halt_d && nxt_d >= 9'(smis_pkg::PROG_SIZE)) begin
			halt_d = 1'b1;
		end
	end

	assign sts.iterate = iter_d;
	assign sts.iter_done = is_root_q ? (bit_q == '0) : (cnt_q == 6'd0);

	logic [31:0] ax, ay, mul_lo;
	assign ax = x_q[31] ? (32'd0 - x_q) : x_q;
	assign ay = y_q[31] ? (32'd0 - y_q) : y_q;
	assign mul_lo = x_q * y_q;

	// divide step: shift in next dividend bit
	logic [32:0] rem_sh;
	assign rem_sh = {acc_q, quo_q[31]};
	logic [31:0] sum_rb;
	assign sum_rb = rtop_q + bit_q;

	logic [smis_pkg::DPTR_W-1:0] top_ix, nxt_ix;
	assign top_ix = smis_pkg::DPTR_W'(dcnt_q - 1'b1);
	assign nxt_ix = smis_pkg::DPTR_W'(dcnt_q - 2'd2);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pc_q <= pc;
			op_q <= opcode;
			a1_q <= operand_one;
			a2_q <= operand_two;
			inval_q <= input_value;
		end
		if (cmd.rd_top) begin
			x_q <= dstk[top_ix];
			rtop_q <= {24'd0, rstk[smis_pkg::RPTR_W'(rcnt_q - 1'b1)]};
		end
		if (cmd.rd_next) y_q <= dstk[nxt_ix];
		if (cmd.decide) begin
			err_q <= err_d;
			nxt_q <= nxt_d;
			halt_q <= halt_d;
			ovalid_q <= (op_q == smis_pkg::OP_OUT) && (err_d == smis_pkg::ERR_NONE);
			is_root_q <= op_q == smis_pkg::OP_ROOT;
			neg_q <= x_q[31] ^ y_q[31];
			cnt_q <= 6'd32;
			acc_q <= '0;
			quo_q <= ax;
			div_q <= ay;
			// root: acc = remaining value, rtop reused as result
			if (op_q == smis_pkg::OP_ROOT) begin
				acc_q <= x_q;
				bit_q <= 32'h4000_0000;
				rtop_q <= '0;
			end
			case (op_q)
				smis_pkg::OP_ADD: res_q <= x_q + y_q;
				smis_pkg::OP_SUB: res_q <= x_q - y_q;
				smis_pkg::OP_MUL: res_q <= mul_lo;
				smis_pkg::OP_OUT: res_q <= x_q;
				default: res_q <= x_q;
			endcase
		end
		if (cmd.iter) begin
			if (is_root_q) begin
				if (acc_q >= sum_rb) begin
					acc_q <= acc_q - sum_rb;
					rtop_q <= (rtop_q >> 1) + bit_q;
				end else begin
					rtop_q <= rtop_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				cnt_q <= cnt_q - 6'd1;
				if (rem_sh >= {1'b0, div_q}) begin
					acc_q <= 32'(rem_sh - {1'b0, div_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					acc_q <= rem_sh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
		end
		if (cmd.commit && err_q == smis_pkg::ERR_NONE) begin
			case (op_q)
				smis_pkg::OP_PUSH:
					dstk[smis_pkg::DPTR_W'(dcnt_q)] <= is_reg ? regs_q[ridx] : v32;
				smis_pkg::OP_PUSHM:
					dstk[smis_pkg::DPTR_W'(dcnt_q)] <= ram_q[smis_pkg::RAM_W'(v8)];
				smis_pkg::OP_IN: dstk[smis_pkg::DPTR_W'(dcnt_q)] <= inval_q;
				smis_pkg::OP_ADD, smis_pkg::OP_SUB, smis_pkg::OP_MUL:
					dstk[nxt_ix] <= res_q;
				smis_pkg::OP_DIV:
					dstk[nxt_ix] <= neg_q ? (32'd0 - quo_q) : quo_q;
				smis_pkg::OP_ROOT: dstk[top_ix] <= rtop_q;
				smis_pkg::OP_CALL:
					rstk[smis_pkg::RPTR_W'(rcnt_q)] <= pc_q + 8'd2;
				smis_pkg::OP_BNE, smis_pkg::OP_BGT, smis_pkg::OP_BLT, smis_pkg::OP_BEQ:
					if (taken && t8 > pc_q) rstk[smis_pkg::RPTR_W'(rcnt_q)] <= pc_q;
				default: ;
			endcase
		end
	end

	// control and architectural state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			rcnt_q <= '0;
			for (int i = 0; i < 4; i++) regs_q[i] <= smis_pkg::POISON;
			for (int i = 0; i < smis_pkg::RAM_WORDS; i++) ram_q[i] <= smis_pkg::POISON;
		end else if (cmd.commit && err_q == smis_pkg::ERR_NONE) begin
			case (op_q)
				smis_pkg::OP_PUSH, smis_pkg::OP_PUSHM, smis_pkg::OP_IN:
					dcnt_q <= dcnt_q + 1'b1;
				smis_pkg::OP_POP: begin
					dcnt_q <= dcnt_q - 1'b1;
					regs_q[ridx] <= x_q;
				end
				smis_pkg::OP_POPM: begin
					dcnt_q <= dcnt_q - 1'b1;
					ram_q[smis_pkg::RAM_W'(v8)] <= x_q;
				end
				smis_pkg::OP_ADD, smis_pkg::OP_SUB, smis_pkg::OP_MUL, smis_pkg::OP_DIV: begin
					dcnt_q <= dcnt_q - 1'b1;
					regs_q[0] <= x_q;
					regs_q[1] <= y_q;
				end
				smis_pkg::OP_ROOT: regs_q[0] <= x_q;
				smis_pkg::OP_CALL: rcnt_q <= rcnt_q + 1'b1;
				smis_pkg::OP_RET: rcnt_q <= rcnt_q - 1'b1;
				smis_pkg::OP_BNE, smis_pkg::OP_BGT, smis_pkg::OP_BLT, smis_pkg::OP_BEQ:
					if (taken && t8 > pc_q) rcnt_q <= rcnt_q + 1'b1;
				smis_pkg::OP_COPY:
					if (is_reg) regs_q[ridx] <= x_q;
				default: ;
			endcase
		end
	end

	assign next_pc = nxt_q[7:0];
	assign out_value = ovalid_q ? res_q : 32'd0;
	assign out_valid = ovalid_q;
	assign halted = halt_q;
	assign error_code = err_q;
endmodule

### rtl/stack_machine_instruction_step_unit.sv
// top level of the stack machine instruction step unit
// one instruction per beat; after accept the unit steps through read, decide, write-back and result states
// divide and root also pass through an iterative state in the shared shift-subtract unit
// the next beat is taken only after the result beat has left
// reset clears stack counts, fills registers and ram with 0x80000000, stacks unwritten
`timescale 1ns / 1ps
module stack_machine_instruction_step_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         pc,
	input  logic [7:0]         opcode,
	input  logic [7:0]         operand_one,
	input  logic [7:0]         operand_two,
	input  logic signed [31:0] input_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [7:0]         next_pc,
	output logic signed [31:0] out_value,
	output logic               out_valid,
	output logic               halted,
	output logic [3:0]         error_code
);
	smis_pkg::cmd_t cmd;
	smis_pkg::sts_t sts;

	smis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid_hs(res_valid), .out_stall(res_stall), .sts(sts), .cmd(cmd)
	);

	smis_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .pc(pc), .opcode(opcode),
		.operand_one(operand_one), .operand_two(operand_two),
		.input_value(input_value), .next_pc(next_pc), .out_value(out_value),
		.out_valid(out_valid), .halted(halted), .error_code(error_code)
	);
endmodule
